// ===== sv/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// Breakpoint address table package
// Shared widths, request codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam int BP_SLOTS_DEF = 16;
    localparam int ADDR_W       = 16;
    localparam int REQ_W        = 3;
    localparam int CNT_OUT_W    = 5;

    localparam logic [ADDR_W-1:0] EMPTY_MARK = 16'hFFFF;

    localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_TEMP = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CHECK    = 3'd4;

    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sel;
    } t_row_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_APPEND
    } t_state;

endpackage

// ===== sv/bat_req_if.sv =====
// ----------------------------------------------------------------------------
// Breakpoint request channel
// Valid/ready channel carrying one table request word.
// ----------------------------------------------------------------------------
interface bat_req_if;
    import bat_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic              which_processor;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output req_type, output which_processor,
                    output address, input ready);
    modport sink   (input valid, input req_type, input which_processor,
                    input address, output ready);

endinterface

// ===== sv/bat_res_if.sv =====
// ----------------------------------------------------------------------------
// Breakpoint result channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface bat_res_if;
    import bat_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output ok, output entry_count, input ready);
    modport sink   (input valid, input ok, input entry_count, output ready);

endinterface

// ===== sv/bat_cell.sv =====
// ----------------------------------------------------------------------------
// Breakpoint table cell
// One slot of each table; appends, removes and clears using neighbor flags.
// ----------------------------------------------------------------------------
module bat_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bat_pkg::t_row_cmd         i_cmd,
    input  logic [bat_pkg::ADDR_W-1:0] i_key,
    input  logic [bat_pkg::ADDR_W-1:0] i_last_val,
    input  logic                      i_prev_empty,
    input  logic                      i_next_empty,
    output logic                      o_empty,
    output logic                      o_hit,
    output logic                      o_last,
    output logic [bat_pkg::ADDR_W-1:0] o_val
);
    import bat_pkg::*;

    logic [ADDR_W-1:0] r_slot [2];
    logic              w_first;

    always_comb begin
        o_val   = r_slot[i_cmd.sel];
        o_empty = (o_val == EMPTY_MARK);
        o_hit   = (o_val == i_key) && (i_key != EMPTY_MARK);
        o_last  = !o_empty && i_next_empty;
        w_first = o_empty && !i_prev_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot[0] <= EMPTY_MARK;
            r_slot[1] <= EMPTY_MARK;
        end else begin
            unique case (i_cmd.op)
                CELL_APPEND: begin
                    if (w_first) begin
                        r_slot[i_cmd.sel] <= i_key;
                    end
                end
                CELL_REMOVE: begin
                    if (o_last) begin
                        r_slot[i_cmd.sel] <= EMPTY_MARK;
                    end else if (o_hit) begin
                        r_slot[i_cmd.sel] <= i_last_val;
                    end
                end
                CELL_CLEAR: begin
                    r_slot[i_cmd.sel] <= EMPTY_MARK;
                end
                CELL_NOP: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/bat_row.sv =====
// ----------------------------------------------------------------------------
// Breakpoint table row
// Chain of slot cells; gathers the match flag and the last live entry.
// ----------------------------------------------------------------------------
module bat_row #(
    parameter int SLOTS = bat_pkg::BP_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bat_pkg::t_row_cmd          i_cmd,
    input  logic [bat_pkg::ADDR_W-1:0] i_key,
    output logic                       o_hit
);
    import bat_pkg::*;

    logic [SLOTS-1:0]  w_empty;
    logic [SLOTS-1:0]  w_hit;
    logic [SLOTS-1:0]  w_last;
    logic [SLOTS-1:0]  w_prev_empty;
    logic [SLOTS-1:0]  w_next_empty;
    logic [ADDR_W-1:0] w_val [SLOTS];
    logic [ADDR_W-1:0] w_last_val;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_lo
            assign w_prev_empty[g] = 1'b0;
        end else begin : g_mid_lo
            assign w_prev_empty[g] = w_empty[g-1];
        end
        if (g == SLOTS - 1) begin : g_hi
            assign w_next_empty[g] = 1'b1;
        end else begin : g_mid_hi
            assign w_next_empty[g] = w_empty[g+1];
        end

        bat_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_key        (i_key),
            .i_last_val   (w_last_val),
            .i_prev_empty (w_prev_empty[g]),
            .i_next_empty (w_next_empty[g]),
            .o_empty      (w_empty[g]),
            .o_hit        (w_hit[g]),
            .o_last       (w_last[g]),
            .o_val        (w_val[g])
        );
    end

    always_comb begin
        w_last_val = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (w_last[k]) begin
                w_last_val = w_last_val | w_val[k];
            end
        end
    end

    assign o_hit = |w_hit;

`ifndef ASSERT_OFF
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("address matches more than one live slot");

    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_last))
        else $error("more than one slot marked as last live entry");
`endif

endmodule

// ===== sv/breakpoint_address_table_core.sv =====
// ----------------------------------------------------------------------------
// Breakpoint address table core
// Two breakpoint tables (main and peripheral processor) with temporaries.
// ----------------------------------------------------------------------------
// Usage: requests enter on i_req (req_type, which_processor, address); one
// result word (ok, entry_count) leaves on o_res for every request. Both are
// valid/ready channels.
// Add, remove, clear, check and unknown codes take 2 cycles: one to accept
// the word and one in which the row of slot cells compares the key and
// updates in place. Set-temporary takes 3 cycles: one extra row pass removes
// the old temporary before the new address is appended.
// The result is registered; the next request is accepted while it waits.
// If the receiver stalls, a finished operation holds in its last step until
// the result register frees up.
// Reset empties both tables, zeroes both counts and clears both temporaries;
// the block accepts a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module breakpoint_address_table_core #(
    parameter int BP_SLOTS = bat_pkg::BP_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bat_req_if.sink      i_req,
    bat_res_if.source    o_res
);
    import bat_pkg::*;

    localparam int CNT_W = $clog2(BP_SLOTS + 1);

    t_state               r_state, n_state;
    logic [REQ_W-1:0]     r_req;
    logic                 r_sel;
    logic [ADDR_W-1:0]    r_addr;
    logic [CNT_W-1:0]     r_cnt [2];
    logic [ADDR_W-1:0]    r_temp [2];
    logic                 r_out_valid;
    logic                 r_ok;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic [CNT_W-1:0]     n_cnt;
    logic [ADDR_W-1:0]    n_temp;
    logic [CNT_W-1:0]     w_cnt;
    logic [ADDR_W-1:0]    w_temp;
    logic [CNT_W+CNT_OUT_W-1:0] w_cnt_ext;
    logic                 w_out_free;
    logic                 w_load;
    logic                 w_ok;
    logic                 w_hit;
    logic [ADDR_W-1:0]    w_key;
    t_row_cmd             w_cmd;

    assign w_cnt      = r_cnt[r_sel];
    assign w_temp     = r_temp[r_sel];
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_key      = (r_state == ST_EXEC && r_req == REQ_SET_TEMP) ? w_temp : r_addr;
    assign w_cnt_ext  = (CNT_W + CNT_OUT_W)'(n_cnt);

    bat_row #(
        .SLOTS (BP_SLOTS)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_key   (w_key),
        .o_hit   (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_temp[0]   <= EMPTY_MARK;
            r_temp[1]   <= EMPTY_MARK;
        end else begin
            r_state      <= n_state;
            r_cnt[r_sel] <= n_cnt;
            r_temp[r_sel] <= n_temp;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req  <= REQ_CHECK;
            r_sel  <= 1'b0;
            r_addr <= EMPTY_MARK;
        end else if (i_req.valid && i_req.ready) begin
            r_req  <= i_req.req_type;
            r_sel  <= i_req.which_processor;
            r_addr <= i_req.address;
        end
        if (w_load) begin
            r_ok      <= w_ok;
            r_out_cnt <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = w_cnt;
        n_temp    = w_temp;
        w_load    = 1'b0;
        w_ok      = 1'b0;
        w_cmd.op  = CELL_NOP;
        w_cmd.sel = r_sel;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_req == REQ_SET_TEMP) begin
                    if (w_hit) begin
                        w_cmd.op = CELL_REMOVE;
                        n_cnt    = w_cnt - 1'b1;
                    end
                    n_temp  = EMPTY_MARK;
                    n_state = ST_APPEND;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                    priority case (r_req)
                        REQ_ADD: begin
                            w_ok = (r_addr != EMPTY_MARK) && !w_hit
                                && (w_cnt < CNT_W'(BP_SLOTS - 1));
                            if (w_ok) begin
                                w_cmd.op = CELL_APPEND;
                                n_cnt    = w_cnt + 1'b1;
                            end
                        end
                        REQ_REMOVE: begin
                            w_ok = w_hit;
                            if (w_hit) begin
                                w_cmd.op = CELL_REMOVE;
                                n_cnt    = w_cnt - 1'b1;
                                if (w_temp == r_addr) begin
                                    n_temp = EMPTY_MARK;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            w_cmd.op = CELL_CLEAR;
                            n_cnt    = '0;
                        end
                        REQ_CHECK: begin
                            w_ok = w_hit;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_APPEND: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                    if ((r_addr != EMPTY_MARK) && !w_hit && (w_cnt < CNT_W'(BP_SLOTS))) begin
                        w_cmd.op = CELL_APPEND;
                        n_cnt    = w_cnt + 1'b1;
                        n_temp   = r_addr;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.ok          = r_ok;
    assign o_res.entry_count = r_out_cnt;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CNT_W'(BP_SLOTS)) && (r_cnt[1] <= CNT_W'(BP_SLOTS)))
        else $error("table count exceeds slot count");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result overwritten while still waiting");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_req == REQ_REMOVE && w_load && w_hit)
        |=> r_cnt[$past(r_sel)] == CNT_W'($past(w_cnt) - 1'b1))
        else $error("successful remove did not decrement count");
`endif

endmodule
